// ----- rtl/core/ordered_key_list_engine_defines.svh -----
// ----------------------------------------------------------------------------
// Ordered key list engine: assertion macros
// Shared assertion macros for the ordered key list engine RTL.
// ----------------------------------------------------------------------------
`ifndef ORDERED_KEY_LIST_ENGINE_DEFINES_SVH
`define ORDERED_KEY_LIST_ENGINE_DEFINES_SVH

`ifndef ASSERT_OFF
// Checks a property at every rising clock edge outside reset.
`define OKLE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Checks an implication at every rising clock edge outside reset.
`define OKLE_ASSERT_IMPL(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
`else
`define OKLE_ASSERT(lbl, clk, rst, prop, msg)
`define OKLE_ASSERT_IMPL(lbl, clk, rst, pre, post, msg)
`endif

`endif

// ----- rtl/core/okle_pkg.sv -----
// ----------------------------------------------------------------------------
// Ordered key list engine package
// Command codes, status codes and field widths of the ordered key list engine.
// ----------------------------------------------------------------------------
package okle_pkg;

   localparam int OKLE_CAPACITY    = 16;
   localparam int OKLE_MAX_RESULTS = 16;

   localparam int OP_W     = 4;
   localparam int KEY_W    = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;
   localparam int INDEX_W  = 4;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 48;

   localparam logic [OP_W-1:0] OP_CLEAR      = 4'd0;
   localparam logic [OP_W-1:0] OP_INS_SORTED = 4'd1;
   localparam logic [OP_W-1:0] OP_INS_FRONT  = 4'd2;
   localparam logic [OP_W-1:0] OP_INS_BACK   = 4'd3;
   localparam logic [OP_W-1:0] OP_DEL_KEY    = 4'd4;
   localparam logic [OP_W-1:0] OP_DEL_FRONT  = 4'd5;
   localparam logic [OP_W-1:0] OP_DEL_BACK   = 4'd6;
   localparam logic [OP_W-1:0] OP_REVERSE    = 4'd7;
   localparam logic [OP_W-1:0] OP_READ_OUT   = 4'd8;

   localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_EMPTY     = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd3;

endpackage

// ----- rtl/core/ordered_key_list_engine.sv -----
// ----------------------------------------------------------------------------
// Ordered key list engine
// Keeps up to CAPACITY signed keys in one on-chip memory, front at address
// zero, and applies list commands to it by read-modify-write passes. Each
// command answers with one word holding status and count; a read-out answers
// with one word per key (at most sixteen), the final one marked by tlast.
// Clear, insert at the back, delete at the back, the unused codes, reverse
// of a single key, read-out of an empty list and every refused command go
// straight from acceptance to the final state. Sorted insert, insert at
// the front and delete of a key make one pass over the list through the
// single memory read port; delete at the front skips the first entry.
// Reverse swaps one pair of entries at a time, in states S_RVA, S_RVB, S_RVW
// and S_RVX, since each swap needs two reads and two writes on the one read
// and one write port. A read-out delivers one key per cycle while the output
// is not stalled.
// A new command is taken only once the previous one has finished its memory
// work and passed its result to the output register, where it may still wait.
// ----------------------------------------------------------------------------
`include "ordered_key_list_engine_defines.svh"

module ordered_key_list_engine
   import okle_pkg::*;
#(
   parameter int CAPACITY = OKLE_CAPACITY
) (
   input  logic                  clock,
   input  logic                  reset,
   // req_tdata: operation [3:0], key_value [35:4], zero fill [39:36]
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // rsp_tdata: status [1:0], entry_count [6:2], entry_index [10:7],
   // entry_key [42:11], zero fill [47:43]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = CW + 5;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_INS  = 4'd1;
   localparam logic [3:0] S_DEL  = 4'd2;
   localparam logic [3:0] S_RVA  = 4'd3;
   localparam logic [3:0] S_RVB  = 4'd4;
   localparam logic [3:0] S_RVW  = 4'd5;
   localparam logic [3:0] S_RVX  = 4'd6;
   localparam logic [3:0] S_RO   = 4'd7;
   localparam logic [3:0] S_FIN  = 4'd8;

   localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);
   localparam logic [CW-1:0] ONE     = CW'(1);

   // Key memory.
   logic [KEY_W-1:0] mem [CAPACITY];
   logic [KEY_W-1:0] rd_data_ff;
   logic [CW-1:0]    rd_pos;
   logic [AW-1:0]    rd_addr;
   logic             mem_we;
   logic [CW-1:0]    mem_wpos;
   logic [KEY_W-1:0] mem_wdata;

   // Control state.
   logic [3:0]          state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       pos_ff, pos_in;
   logic [CW-1:0]       aux_ff, aux_in;
   logic                flag_ff, flag_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [KEY_W-1:0]    carry_ff, carry_in;
   logic [STATUS_W-1:0] status_ff, status_in;

   // Output register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic [INDEX_W-1:0]  rsp_index_ff, rsp_index_in;
   logic [KEY_W-1:0]    rsp_key_ff, rsp_key_in;
   logic                rsp_last_ff, rsp_last_in;

   logic [OP_W-1:0]  req_op;
   logic [KEY_W-1:0] req_key;
   logic             req_fire;
   logic             out_free;
   logic [XW-1:0]    count_x;
   logic [XW-1:0]    pos_x;
   logic [XW-1:0]    aux_x;
   logic             ro_take;
   logic             ro_last;

   assign req_op   = req_tdata[OP_W-1:0];
   assign req_key  = req_tdata[OP_W+KEY_W-1:OP_W];
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   assign count_x = {5'b0, count_ff};
   assign pos_x   = {5'b0, pos_ff};
   assign aux_x   = {5'b0, aux_ff};

   // In a read-out, pos_ff is the position whose key sits in rd_data_ff and
   // flag_ff says that key is live; aux_ff is the next position to fetch.
   assign ro_take = flag_ff && out_free;
   assign ro_last = (pos_x + XW'(1) == count_x) || (pos_x == XW'(OKLE_MAX_RESULTS - 1));

   assign rd_addr = (rd_pos < CAP_CNT) ? rd_pos[AW-1:0] : '0;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wpos[AW-1:0]] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      aux_in        = aux_ff;
      flag_in       = flag_ff;
      key_in        = key_ff;
      carry_in      = carry_ff;
      status_in     = status_ff;
      rd_pos        = '0;
      mem_we        = 1'b0;
      mem_wpos      = '0;
      mem_wdata     = '0;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               key_in    = req_key;
               status_in = STAT_OK;
               state_in  = S_FIN;
               unique case (req_op)
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  OP_INS_SORTED, OP_INS_FRONT, OP_INS_BACK: begin
                     if (count_ff == CAP_CNT) begin
                        status_in = STAT_FULL;
                     end else if (req_op == OP_INS_BACK) begin
                        mem_we    = 1'b1;
                        mem_wpos  = count_ff;
                        mem_wdata = req_key;
                        count_in  = count_ff + ONE;
                     end else begin
                        pos_in   = '0;
                        carry_in = req_key;
                        flag_in  = (req_op == OP_INS_FRONT);
                        state_in = S_INS;
                     end
                  end
                  OP_DEL_KEY: begin
                     if (count_ff == '0) begin
                        status_in = STAT_EMPTY;
                     end else begin
                        pos_in   = '0;
                        flag_in  = 1'b0;
                        state_in = S_DEL;
                     end
                  end
                  OP_DEL_FRONT: begin
                     if (count_ff == '0) begin
                        status_in = STAT_EMPTY;
                     end else begin
                        // Start one entry in, already shifting down.
                        rd_pos   = ONE;
                        pos_in   = ONE;
                        flag_in  = 1'b1;
                        state_in = S_DEL;
                     end
                  end
                  OP_DEL_BACK: begin
                     if (count_ff == '0) begin
                        status_in = STAT_EMPTY;
                     end else begin
                        count_in = count_ff - ONE;
                     end
                  end
                  OP_REVERSE: begin
                     if (count_ff == '0) begin
                        status_in = STAT_EMPTY;
                     end else begin
                        pos_in = '0;
                        aux_in = count_ff - ONE;
                        if (count_ff > ONE) begin
                           state_in = S_RVA;
                        end
                     end
                  end
                  OP_READ_OUT: begin
                     if (count_ff == '0) begin
                        status_in = STAT_EMPTY;
                     end else begin
                        aux_in   = '0;
                        flag_in  = 1'b0;
                        state_in = S_RO;
                     end
                  end
                  default: begin
                     status_in = STAT_OK;
                  end
               endcase
            end
         end

         S_INS: begin
            // The new key ripples in as a carry, each displaced key moving up.
            rd_pos = pos_ff + ONE;
            if (pos_ff == count_ff) begin
               mem_we    = 1'b1;
               mem_wpos  = pos_ff;
               mem_wdata = carry_ff;
               count_in  = count_ff + ONE;
               state_in  = S_FIN;
            end else begin
               if (flag_ff || ($signed(rd_data_ff) >= $signed(key_ff))) begin
                  mem_we    = 1'b1;
                  mem_wpos  = pos_ff;
                  mem_wdata = carry_ff;
                  carry_in  = rd_data_ff;
                  flag_in   = 1'b1;
               end
               pos_in = pos_ff + ONE;
            end
         end

         S_DEL: begin
            // After the match, every later key is written one place lower.
            rd_pos = pos_ff + ONE;
            if (pos_ff == count_ff) begin
               if (flag_ff) begin
                  count_in = count_ff - ONE;
               end else begin
                  status_in = STAT_NOT_FOUND;
               end
               state_in = S_FIN;
            end else begin
               if (flag_ff) begin
                  mem_we    = 1'b1;
                  mem_wpos  = pos_ff - ONE;
                  mem_wdata = rd_data_ff;
               end else if (rd_data_ff == key_ff) begin
                  flag_in = 1'b1;
               end
               pos_in = pos_ff + ONE;
            end
         end

         S_RVA: begin
            rd_pos   = pos_ff;
            state_in = S_RVB;
         end

         S_RVB: begin
            rd_pos   = aux_ff;
            carry_in = rd_data_ff;
            state_in = S_RVW;
         end

         S_RVW: begin
            mem_we    = 1'b1;
            mem_wpos  = pos_ff;
            mem_wdata = rd_data_ff;
            state_in  = S_RVX;
         end

         S_RVX: begin
            mem_we    = 1'b1;
            mem_wpos  = aux_ff;
            mem_wdata = carry_ff;
            pos_in    = pos_ff + ONE;
            aux_in    = aux_ff - ONE;
            if (pos_x + XW'(2) < aux_x) begin
               state_in = S_RVA;
            end else begin
               state_in = S_FIN;
            end
         end

         S_RO: begin
            if (ro_take) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_OK;
               rsp_count_in  = count_x[COUNT_W-1:0];
               rsp_index_in  = pos_x[INDEX_W-1:0];
               rsp_key_in    = rd_data_ff;
               rsp_last_in   = ro_last;
            end
            if (ro_take && ro_last) begin
               flag_in  = 1'b0;
               state_in = S_IDLE;
            end else if (flag_ff && !ro_take) begin
               // Output stalled: fetch the same entry again to hold its key.
               rd_pos = pos_ff;
            end else if ((aux_ff < count_ff) && (aux_x < XW'(OKLE_MAX_RESULTS))) begin
               rd_pos  = aux_ff;
               pos_in  = aux_ff;
               aux_in  = aux_ff + ONE;
               flag_in = 1'b1;
            end else begin
               flag_in = 1'b0;
            end
         end

         S_FIN: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_count_in  = count_x[COUNT_W-1:0];
               rsp_index_in  = '0;
               rsp_key_in    = '0;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         flag_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         flag_ff      <= flag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      aux_ff        <= aux_in;
      key_ff        <= key_in;
      carry_ff      <= carry_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {5'b0, rsp_key_ff, rsp_index_ff, rsp_count_ff, rsp_status_ff};

   `OKLE_ASSERT(a_count_bound, clock, reset, count_ff <= CAP_CNT, "list count above capacity")
   `OKLE_ASSERT_IMPL(a_write_in_list, clock, reset, mem_we, mem_wpos <= count_ff, "memory write beyond list end")
   `OKLE_ASSERT_IMPL(a_ro_pos_valid, clock, reset, (state_ff == S_RO) && flag_ff, pos_ff < count_ff, "read-out position beyond list end")
   `OKLE_ASSERT_IMPL(a_mid_word_in_ro, clock, reset, rsp_valid_ff && !rsp_last_ff, state_ff == S_RO, "non-final word outside a read-out")

endmodule
